@@ src/vtew_pkg.sv @@
// ----------------------------------------------------------------------------
// vtew_pkg
// Shared types and constants for the tab-expanding, line-wrapping text filter.
// ----------------------------------------------------------------------------
package vtew_pkg;

  localparam int CHAR_W        = 21;
  localparam int COL_W         = 16;
  localparam int WRAP_W        = 8;
  localparam int TAB_WIDTH_DEF = 8;

  localparam logic [CHAR_W-1:0] CH_NUL    = 21'd0;
  localparam logic [CHAR_W-1:0] CH_BS     = 21'd8;
  localparam logic [CHAR_W-1:0] CH_TAB    = 21'd9;
  localparam logic [CHAR_W-1:0] CH_NL     = 21'd10;
  localparam logic [CHAR_W-1:0] CH_VT     = 21'd11;
  localparam logic [CHAR_W-1:0] CH_FF     = 21'd12;
  localparam logic [CHAR_W-1:0] CH_CR     = 21'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 21'd32;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 21'd92;
  localparam logic [CHAR_W-1:0] CH_DEL    = 21'd127;

  // Input character classes.
  typedef enum logic [1:0] {
    K_DROP,
    K_NEWLINE,
    K_SPACE,
    K_OTHER
  } kind_t;

  // Output character selection.
  typedef enum logic [1:0] {
    SEL_NL,
    SEL_BSLASH,
    SEL_SPACE,
    SEL_CHAR
  } sel_t;

  typedef struct packed {
    logic load;     // input item accepted this cycle
    logic cnt_dec;  // one space delivered
    sel_t sel;      // character shown on the output
  } cmd_t;

  typedef struct packed {
    kind_t kind;       // class of the offered input
    logic  brk_pre;    // an ordinary character must break the line first
    logic  brk_post;   // the space run of the current item ends in a break
    logic  cnt_one;    // the last space of the run is being shown
  } status_t;

endpackage

@@ src/verbatim_tab_expand_wrap_unit.sv @@
// ----------------------------------------------------------------------------
// verbatim_tab_expand_wrap_unit
// Character filter that drops invisible control codes, expands tabs to
// spaces and breaks long lines with a backslash and a newline.
// ----------------------------------------------------------------------------
// Usage: each input item is one character code on in_char_in, taken when
// in_valid and in_ready are both high. The results of that item follow on
// out_char_out, one per accepted out_valid/out_ready cycle, and out_last
// marks the final result of the item. Dropped codes give no result at all.
// The single configuration register, the wrap width, is written over the
// cfg channel, which is always ready; zero turns line wrapping off.
// Timing: the block works on one item at a time. It accepts an item in its
// idle cycle and shows the first result in the next cycle. A dropped code
// gives no result; an ordinary character may be preceded by a backslash
// and a newline, and a space or a tab gives its spaces, which may end in a
// line break. The controller sequences the results, and one result leaves
// per cycle while the receiver does not stall.
// A stall on out_ready simply holds the current result; the block takes
// no new item until the last result of the current one has been taken.
// Reset clears the column count and the wrap width to zero.
// ----------------------------------------------------------------------------
module verbatim_tab_expand_wrap_unit
  import vtew_pkg::*;
#(
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WRAP_W-1:0] cfg_wrap_width,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_last
);

  cmd_t    cmd;
  status_t sts;

  // The register may be written at any cycle the host chooses.
  assign cfg_ready = 1'b1;

  // The controller decides the order of results; the datapath keeps the
  // column state and picks the character that goes out.
  vtew_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .sts       (sts),
    .cmd       (cmd)
  );

  vtew_dp #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_wrap_width (cfg_wrap_width),
    .in_char_in     (in_char_in),
    .out_char_out   (out_char_out),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

@@ src/vtew_ctrl.sv @@
// ----------------------------------------------------------------------------
// vtew_ctrl
// Controller: sequences the results of one item and runs both handshakes.
// ----------------------------------------------------------------------------
module vtew_ctrl
  import vtew_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_last,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NL,
    S_SPACES,
    S_POST_BS,
    S_POST_NL,
    S_PRE_BS,
    S_PRE_NL,
    S_CHAR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (sts.kind)
            K_DROP:    state_nxt = S_IDLE;
            K_NEWLINE: state_nxt = S_NL;
            K_SPACE:   state_nxt = S_SPACES;
            K_OTHER:   state_nxt = sts.brk_pre ? S_PRE_BS : S_CHAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_NL:      if (out_ready) state_nxt = S_IDLE;
      S_SPACES: begin
        if (out_ready && sts.cnt_one) begin
          state_nxt = sts.brk_post ? S_POST_BS : S_IDLE;
        end
      end
      S_POST_BS: if (out_ready) state_nxt = S_POST_NL;
      S_POST_NL: if (out_ready) state_nxt = S_IDLE;
      S_PRE_BS:  if (out_ready) state_nxt = S_PRE_NL;
      S_PRE_NL:  if (out_ready) state_nxt = S_CHAR;
      S_CHAR:    if (out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r != S_IDLE);

  always_comb begin
    unique case (state_r)
      S_NL, S_POST_NL, S_CHAR: out_last = 1'b1;
      S_SPACES:                out_last = sts.cnt_one && !sts.brk_post;
      default:                 out_last = 1'b0;
    endcase
  end

  always_comb begin
    cmd.load    = in_valid && (state_r == S_IDLE);
    cmd.cnt_dec = out_ready && (state_r == S_SPACES);
    unique case (state_r)
      S_NL, S_POST_NL, S_PRE_NL: cmd.sel = SEL_NL;
      S_POST_BS, S_PRE_BS:       cmd.sel = SEL_BSLASH;
      S_SPACES:                  cmd.sel = SEL_SPACE;
      default:                   cmd.sel = SEL_CHAR;
    endcase
  end

endmodule

@@ src/vtew_dp.sv @@
// ----------------------------------------------------------------------------
// vtew_dp
// Datapath: column and tab-stop counters, wrap limits and the output mux.
// ----------------------------------------------------------------------------
module vtew_dp
  import vtew_pkg::*;
#(
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [WRAP_W-1:0] cfg_wrap_width,
  input  logic [CHAR_W-1:0] in_char_in,
  output logic [CHAR_W-1:0] out_char_out,
  input  cmd_t              cmd,
  output status_t           sts
);

  localparam int CNT_W = $clog2(TAB_WIDTH + 1);
  localparam int POS_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam logic [CNT_W-1:0] TW_C   = CNT_W'(TAB_WIDTH);
  // Shift of the tab-stop phase when the column wraps past its top.
  localparam logic [CNT_W-1:0] WRAP_K = CNT_W'((1 << COL_W) % TAB_WIDTH);
  localparam logic [POS_W-1:0] ONE_POS = POS_W'(1 % TAB_WIDTH);
  // x / 3 for 8-bit x is (x * 171) >> 9.
  localparam logic [15:0] RECIP3 = 16'd171;

  logic [COL_W-1:0]  col_r;
  logic [POS_W-1:0]  pos_r;      // col_r modulo TAB_WIDTH
  logic [CNT_W-1:0]  cnt_r;
  logic              brk_r;
  logic [CHAR_W-1:0] char_r;
  logic [WRAP_W-1:0] wrap_r, space_lim_r, char_lim_r;

  kind_t             kind;
  logic              wrap_on;
  logic [CNT_W-1:0]  n;
  logic [COL_W:0]    col_sum;
  logic [CNT_W-1:0]  pos_sum, pos_red, pos_adj;
  logic [15:0]       lim_prod;
  logic              brk_space, brk_other;

  always_comb begin
    unique case (in_char_in) inside
      CH_NUL, CH_DEL, CH_BS, CH_CR, CH_FF, CH_VT: kind = K_DROP;
      CH_NL:                                      kind = K_NEWLINE;
      CH_SPACE, CH_TAB:                           kind = K_SPACE;
      default:                                    kind = K_OTHER;
    endcase
  end

  assign wrap_on = (wrap_r != '0);

  // Step taken by the column on this item: a run of spaces or one character.
  assign n = (kind == K_SPACE && in_char_in == CH_TAB) ?
             (TW_C - CNT_W'(pos_r)) : CNT_W'(1);

  assign col_sum = {1'b0, col_r} + (COL_W + 1)'(n);

  // Keep the tab-stop phase in step with the column, including its wrap.
  always_comb begin
    pos_sum = CNT_W'(pos_r) + n;
    pos_red = (pos_sum >= TW_C) ? (pos_sum - TW_C) : pos_sum;
    if (col_sum[COL_W]) begin
      pos_adj = (pos_red >= WRAP_K) ? (pos_red - WRAP_K) : (pos_red + TW_C - WRAP_K);
    end else begin
      pos_adj = pos_red;
    end
  end

  assign brk_space = wrap_on && (col_sum[COL_W-1:0] >= COL_W'(space_lim_r));
  assign brk_other = wrap_on && (col_r >= COL_W'(char_lim_r));

  assign lim_prod = 16'(cfg_wrap_width) * RECIP3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r      <= '0;
      space_lim_r <= WRAP_W'(1);
      char_lim_r  <= '1;
      col_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      brk_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        wrap_r      <= cfg_wrap_width;
        space_lim_r <= {lim_prod[15:9], 1'b1};
        char_lim_r  <= cfg_wrap_width - WRAP_W'(1);
      end
      if (cmd.load) begin
        case (kind)
          K_NEWLINE: begin
            col_r <= '0;
            pos_r <= '0;
          end
          K_SPACE: begin
            cnt_r <= n;
            brk_r <= brk_space;
            col_r <= brk_space ? '0 : col_sum[COL_W-1:0];
            pos_r <= brk_space ? '0 : POS_W'(pos_adj);
          end
          K_OTHER: begin
            col_r <= brk_other ? COL_W'(1) : col_sum[COL_W-1:0];
            pos_r <= brk_other ? ONE_POS : POS_W'(pos_adj);
          end
          default: begin
          end
        endcase
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_in;
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_NL:     out_char_out = CH_NL;
      SEL_BSLASH: out_char_out = CH_BSLASH;
      SEL_SPACE:  out_char_out = CH_SPACE;
      default:    out_char_out = char_r;
    endcase
  end

  assign sts.kind     = kind;
  assign sts.brk_pre  = brk_other;
  assign sts.brk_post = brk_r;
  assign sts.cnt_one  = (cnt_r == CNT_W'(1));

endmodule

@@ dv/tb_verbatim_tab_expand_wrap_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_verbatim_tab_expand_wrap_unit
// Self-checking bench for the tab-expanding, line-wrapping character filter.
// A local predictor tracks the output column and the wrap width, expands
// every accepted character into its expected output characters and checks
// them in order against the result channel, under random idling on both
// sides, a long output stall and a line that grows past the widest wrap width.
// ----------------------------------------------------------------------------
module tb_verbatim_tab_expand_wrap_unit;
  import vtew_pkg::*;

  localparam int TAB_W        = TAB_WIDTH_DEF;
  // Cycles to let pass before a register write so that a dropped code still
  // in flight has surely retired.
  localparam int SETTLE       = 4;
  localparam int RANDOM_ITEMS = 230;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_char_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [WRAP_W-1:0] cfg_wrap_width = '0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] in_char_in     = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [CHAR_W-1:0] out_char_out;
  logic              out_last;

  // Predictor state: its own copy of the column and of the wrap register.
  logic [COL_W-1:0]  column_q   = '0;
  logic [WRAP_W-1:0] wrap_q     = '0;
  out_char_t         pending_chars[$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int          stall_left   = 0;

  int errors      = 0;
  int items_sent  = 0;
  int results_ok  = 0;
  int breaks_seen = 0;
  int cfg_writes  = 0;

  always #5 clk = ~clk;

  verbatim_tab_expand_wrap_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_wrap_width (cfg_wrap_width),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_last       (out_last)
  );

  // --------------------------------------------------------------------------
  // Predictor. Expands one accepted character into the characters the filter
  // must emit and updates the column. The last one carries the last flag.
  // --------------------------------------------------------------------------
  task automatic expand_char(input logic [CHAR_W-1:0] c, output int n_out);
    out_char_t seq[$];
    int        n_sp;
    int        space_lim;
    int        char_lim;
    logic      wrap_on;
    wrap_on   = (wrap_q != '0);
    space_lim = 1 + 2 * (int'(wrap_q) / 3);
    char_lim  = int'(wrap_q) - 1;
    case (c)
      CH_NUL, CH_DEL, CH_BS, CH_CR, CH_FF, CH_VT: begin
        // Invisible control codes vanish and leave the column alone.
      end
      CH_NL: begin
        seq.push_back('{CH_NL, 1'b0});
        column_q = '0;
      end
      CH_SPACE, CH_TAB: begin
        n_sp = (c == CH_TAB) ? TAB_W - (int'(column_q) % TAB_W) : 1;
        repeat (n_sp) seq.push_back('{CH_SPACE, 1'b0});
        column_q = column_q + n_sp[COL_W-1:0];
        // A space run that reaches the soft limit ends the line.
        if (wrap_on && int'(column_q) >= space_lim) begin
          seq.push_back('{CH_BSLASH, 1'b0});
          seq.push_back('{CH_NL, 1'b0});
          column_q = '0;
          breaks_seen++;
        end
      end
      default: begin
        // An ordinary character that would not fit breaks the line first.
        if (wrap_on && int'(column_q) >= char_lim) begin
          seq.push_back('{CH_BSLASH, 1'b0});
          seq.push_back('{CH_NL, 1'b0});
          column_q = '0;
          breaks_seen++;
        end
        seq.push_back('{c, 1'b0});
        column_q = column_q + 1'b1;
      end
    endcase
    n_out = seq.size();
    if (n_out > 0) seq[n_out-1].last = 1'b1;
    foreach (seq[i]) pending_chars.push_back(seq[i]);
  endtask

  // --------------------------------------------------------------------------
  // Result side. Checks every accepted result against the oldest expected
  // character, then decides out_ready for the next cycle: a requested long
  // stall first, otherwise random idling at the current rate.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_char_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected result char=%h last=%b", $time, out_char_out, out_last);
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char_out !== exp_c.ch || out_last !== exp_c.last) begin
          errors++;
          $display("%0t: mismatch expected char=%h last=%b, actual char=%h last=%b",
                   $time, exp_c.ch, exp_c.last, out_char_out, out_last);
        end else begin
          results_ok++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Shared helpers for the input and configuration channels.
  // --------------------------------------------------------------------------

  // Offers one character, with random gaps in front, and returns once it has
  // been taken. The prediction is made at the edge that accepts it.
  task automatic send_char(input logic [CHAR_W-1:0] c, output int n_out);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    expand_char(c, n_out);
  endtask

  task automatic send(input logic [CHAR_W-1:0] c);
    int n;
    send_char(c, n);
  endtask

  // Stops offering, waits for every expected result, then lets a dropped
  // code that may still be in flight retire.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_wrap(input logic [WRAP_W-1:0] w);
    wait_drained();
    cfg_valid      <= 1'b1;
    cfg_wrap_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wrap_q = w;
    cfg_writes++;
  endtask

  // Mostly printable text with spaces and tabs so that lines grow long;
  // newlines are rare, with some control codes and arbitrary code points.
  function automatic logic [CHAR_W-1:0] random_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return CHAR_W'($urandom_range(33, 126));
    if (r < 60) return CH_SPACE;
    if (r < 72) return CH_TAB;
    if (r < 74) return CH_NL;
    if (r < 80) begin
      case ($urandom_range(5))
        0:       return CH_NUL;
        1:       return CH_DEL;
        2:       return CH_BS;
        3:       return CH_CR;
        4:       return CH_FF;
        default: return CH_VT;
      endcase
    end
    if (r < 90) return CHAR_W'($urandom);
    return CHAR_W'($urandom_range(128, 21'h10FFFF));
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Out of reset the wrap width is zero: no breaks, control codes dropped,
  // tab expansion from an odd column, newline clearing the column.
  task automatic test_reset_defaults();
    send(21'h41);      // column 1
    send(CH_TAB);      // seven spaces to the next stop
    send(CH_NUL);
    send(CH_DEL);
    send(CH_BS);
    send(CH_CR);
    send(CH_FF);
    send(CH_VT);
    send(CH_NL);
    send(CH_SPACE);
    send(CH_TAB);
  endtask

  // A wrap width of one breaks before every ordinary character and after
  // every space or tab.
  task automatic test_wrap_of_one();
    write_wrap(8'd1);
    send(21'h42);
    send(21'h43);
    send(CH_SPACE);
    send(CH_TAB);
    send(CH_NL);
  endtask

  // Code points at the top of the field, beyond the Unicode range, surrogates
  // and a literal backslash all pass through as ordinary characters.
  task automatic test_code_extremes();
    write_wrap(8'd3);
    send(21'h1FFFFF);
    send(21'h110000);
    send(21'h10FFFF);
    send(21'h00D800);
    send(CH_BSLASH);
    send(21'h0AAAAA);
    send(21'h155555);
  endtask

  // With wrapping off a line grows well past the widest wrap width. Once a
  // wide wrap width is set, the next ordinary character must break first,
  // and the tab after it stays far below the space limit.
  task automatic test_long_line();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_wrap(8'd0);
    send(CH_NL);
    repeat (40) send(CH_TAB);
    write_wrap(8'd255);
    send(21'h7A);
    send(CH_TAB);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back-to-back, so the filter fills and stalls its input. Then
  // the sender pauses until every expected character has arrived.
  task automatic test_output_stall();
    write_wrap(8'd12);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    stall_left <= 200;
    repeat (16) send(random_char());
    wait_drained();
    stall_left <= 120;
    repeat (8) send(CH_TAB);
    wait_drained();
  endtask

  // Random text under three idling profiles, each split into segments with
  // a randomly chosen wrap width, the extremes among the choices.
  task automatic test_random_text();
    int          real_items;
    int          n;
    int          seg;
    logic [WRAP_W-1:0] w;
    real_items = 0;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin snd_idle_pct = 22; rcv_idle_pct = 48; end
        1: begin snd_idle_pct = 48; rcv_idle_pct = 22; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        case ($urandom_range(5))
          0:       w = 8'd0;
          1:       w = 8'd1;
          2:       w = WRAP_W'($urandom_range(2, 3));
          3:       w = WRAP_W'($urandom_range(254, 255));
          default: w = WRAP_W'($urandom_range(4, 60));
        endcase
        write_wrap(w);
        // Dropped codes do not count toward the segment length.
        while (real_items < (RANDOM_ITEMS * (4 * p + seg + 1)) / 12) begin
          send_char(random_char(), n);
          if (n > 0) real_items++;
        end
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_wrap_of_one();
    test_code_extremes();
    test_long_line();
    test_output_stall();
    test_random_text();
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_chars.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_chars.size());
    end
    $display("Sent %0d characters, checked %0d results with %0d line breaks.",
             items_sent, results_ok, breaks_seen);
    $display("Covered %0d wrap settings, three idle profiles, a long output stall %s",
             cfg_writes, "and a line grown past the widest wrap width.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The slowest correct run stays far below this bound.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
